// ===== rtl/rbvi_pkg.sv =====
// Shared types, codes and saturating arithmetic helpers for the velocity integrator.
`timescale 1ns / 1ps

package rbvi_pkg;

   localparam int DT_FRAC   = 16;
   localparam int DIV_STEPS = 64;

   typedef enum logic [1:0] {
      CMD_FORCE     = 2'd0,
      CMD_TORQUE    = 2'd1,
      CMD_INTEGRATE = 2'd2,
      CMD_NONE      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_MASS  = 2'd0,
      REG_SPEED = 2'd1,
      REG_SPIN  = 2'd2,
      REG_NONE  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] torque_in;
      logic [15:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] ang_vel;
      logic               speed_clamped;
      logic               spin_clamped;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FX_DIV,
      ST_FX_ACC,
      ST_FY_DIV,
      ST_FY_ACC,
      ST_TQ_DIV,
      ST_TQ_ACC,
      ST_VX_MUL,
      ST_VX_ADD,
      ST_VY_MUL,
      ST_VY_ADD,
      ST_SQX_MUL,
      ST_SQY_MUL,
      ST_LIM_MUL,
      ST_CMP,
      ST_SQRT,
      ST_RX_MUL,
      ST_RX_LOAD,
      ST_RX_DIV,
      ST_RX_SET,
      ST_RY_MUL,
      ST_RY_LOAD,
      ST_RY_DIV,
      ST_RY_SET,
      ST_W_MUL,
      ST_W_ADD,
      ST_W_CLAMP,
      ST_DONE
   } state_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   function automatic logic signed [31:0] from_mag(input logic neg, input logic [63:0] q);
      logic signed [31:0] r;
      if (neg) begin
         if (q > 64'h0000_0000_8000_0000) r = 32'sh8000_0000;
         else r = -$signed(q[31:0]);
      end else begin
         if (q > 64'h0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
         else r = $signed(q[31:0]);
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [32:0] s;
      logic signed [31:0] r;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else r = s[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] add_mag(input logic signed [31:0] base,
                                                 input logic neg, input logic [32:0] p);
      logic signed [34:0] d;
      logic signed [34:0] s;
      logic signed [31:0] r;
      d = neg ? -$signed({2'b00, p}) : $signed({2'b00, p});
      s = 35'(base) + d;
      if (s > 35'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (s < -35'sh0_8000_0000) r = 32'sh8000_0000;
      else r = s[31:0];
      return r;
   endfunction

endpackage

// ===== rtl/rigid_body_velocity_integrator_unit.sv =====
// Top level of the rigid body velocity integrator: sequencer, shared multiplier, divider, root.
`timescale 1ns / 1ps
//
// Usage:
//  - req channel carries one command transaction: add force, add torque or integrate.
//    It is taken when req_valid is high and req_stall is low; req_stall stays high
//    from the accepted transaction until its result is loaded into the output register.
//  - rsp channel returns one transaction per command with the velocities and the
//    clamp flags; it holds while rsp_stall is high, and the unit waits at the end
//    of the next command until the output register is free.
//  - csr port writes body_mass, speed_limit or spin_limit; write only while idle.
//  - The sequencer shares one 64-step restoring divider, one 32-step square root unit
//    and one 32x32 multiplier among add force, add torque and integrate; the speed
//    rescale of integrate uses the square root and two divides.
//  - Synchronous reset clears velocities, accumulators and the output valid flag and
//    loads mass 1.0 and both limits 0 (unlimited).
//
module rigid_body_velocity_integrator_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rbvi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rbvi_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata
);

   rbvi_pkg::state_type state_ff, state_in;

   logic [30:0]        mass_ff, mass_in;
   logic [30:0]        slim_ff, slim_in;
   logic [30:0]        wlim_ff, wlim_in;
   logic signed [31:0] ax_ff, ax_in;
   logic signed [31:0] ay_ff, ay_in;
   logic signed [31:0] aw_ff, aw_in;
   logic signed [31:0] vx_ff, vx_in;
   logic signed [31:0] vy_ff, vy_in;
   logic signed [31:0] vw_ff, vw_in;
   logic signed [31:0] fy_ff, fy_in;
   logic [15:0]        dt_ff, dt_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        sum_ff, sum_in;
   logic [63:0]        sq_x_ff, sq_x_in;
   logic [63:0]        sq_res_ff, sq_res_in;
   logic [63:0]        sq_bit_ff, sq_bit_in;
   logic [63:0]        div_num_ff, div_num_in;
   logic [32:0]        div_rem_ff, div_rem_in;
   logic [31:0]        div_den_ff, div_den_in;
   logic [6:0]         div_cnt_ff, div_cnt_in;
   logic               div_neg_ff, div_neg_in;
   logic               div_zero_ff, div_zero_in;
   logic               sclamp_ff, sclamp_in;
   logic               wclamp_ff, wclamp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rbvi_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic [32:0]        div_t;
   logic               div_ge;
   logic [63:0]        sq_t;
   logic signed [31:0] div_q;
   logic signed [31:0] wlim_pos;
   logic signed [31:0] wlim_neg;
   logic               req_take;

   assign req_stall = (state_ff != rbvi_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign div_t    = {div_rem_ff[31:0], div_num_ff[63]};
   assign div_ge   = (div_t >= {1'b0, div_den_ff});
   assign sq_t     = sq_res_ff + sq_bit_ff;
   assign div_q    = div_zero_ff ? 32'sd0 : rbvi_pkg::from_mag(div_neg_ff, div_num_ff);
   assign wlim_pos = $signed({1'b0, wlim_ff});
   assign wlim_neg = -$signed({1'b0, wlim_ff});

   always_comb begin
      state_in     = state_ff;
      mass_in      = mass_ff;
      slim_in      = slim_ff;
      wlim_in      = wlim_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      aw_in        = aw_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vw_in        = vw_ff;
      fy_in        = fy_ff;
      dt_in        = dt_ff;
      sum_in       = sum_ff;
      sq_x_in      = sq_x_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      div_neg_in   = div_neg_ff;
      div_zero_in  = div_zero_ff;
      sclamp_in    = sclamp_ff;
      wclamp_in    = wclamp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_a        = 32'd0;
      mul_b        = 32'd0;

      if (csr_wr_en) begin
         case (rbvi_pkg::reg_index_type'(csr_index))
            rbvi_pkg::REG_MASS:  mass_in = csr_wdata;
            rbvi_pkg::REG_SPEED: slim_in = csr_wdata;
            rbvi_pkg::REG_SPIN:  wlim_in = csr_wdata;
            default: ;
         endcase
      end

      if (div_cnt_ff != 7'd0) begin
         div_rem_in = div_ge ? div_t - {1'b0, div_den_ff} : div_t;
         div_num_in = {div_num_ff[62:0], div_ge};
         div_cnt_in = div_cnt_ff - 7'd1;
      end

      case (state_ff)
         rbvi_pkg::ST_IDLE: begin
            if (req_take) begin
               fy_in     = req_data.force_y;
               dt_in     = req_data.time_step;
               sclamp_in = 1'b0;
               wclamp_in = 1'b0;
               case (rbvi_pkg::cmd_type'(req_data.cmd))
                  rbvi_pkg::CMD_FORCE: begin
                     div_num_in  = 64'(rbvi_pkg::mag32(req_data.force_x)) << FRAC_BITS;
                     div_zero_in = (req_data.force_x == 32'sd0);
                     div_neg_in  = req_data.force_x[31];
                     div_den_in  = {1'b0, mass_ff};
                     div_rem_in  = 33'd0;
                     div_cnt_in  = 7'(rbvi_pkg::DIV_STEPS);
                     state_in    = rbvi_pkg::ST_FX_DIV;
                  end
                  rbvi_pkg::CMD_TORQUE: begin
                     div_num_in  = 64'(rbvi_pkg::mag32(req_data.torque_in)) << FRAC_BITS;
                     div_zero_in = (req_data.torque_in == 32'sd0);
                     div_neg_in  = req_data.torque_in[31];
                     div_den_in  = {1'b0, mass_ff};
                     div_rem_in  = 33'd0;
                     div_cnt_in  = 7'(rbvi_pkg::DIV_STEPS);
                     state_in    = rbvi_pkg::ST_TQ_DIV;
                  end
                  rbvi_pkg::CMD_INTEGRATE: state_in = rbvi_pkg::ST_VX_MUL;
                  default:                 state_in = rbvi_pkg::ST_DONE;
               endcase
            end
         end
         rbvi_pkg::ST_FX_DIV, rbvi_pkg::ST_FY_DIV, rbvi_pkg::ST_TQ_DIV,
         rbvi_pkg::ST_RX_DIV, rbvi_pkg::ST_RY_DIV: begin
            if (div_cnt_ff == 7'd0) begin
               case (state_ff)
                  rbvi_pkg::ST_FX_DIV: state_in = rbvi_pkg::ST_FX_ACC;
                  rbvi_pkg::ST_FY_DIV: state_in = rbvi_pkg::ST_FY_ACC;
                  rbvi_pkg::ST_TQ_DIV: state_in = rbvi_pkg::ST_TQ_ACC;
                  rbvi_pkg::ST_RX_DIV: state_in = rbvi_pkg::ST_RX_SET;
                  default:             state_in = rbvi_pkg::ST_RY_SET;
               endcase
            end
         end
         rbvi_pkg::ST_FX_ACC: begin
            ax_in       = rbvi_pkg::sat_add(ax_ff, div_q);
            div_num_in  = 64'(rbvi_pkg::mag32(fy_ff)) << FRAC_BITS;
            div_zero_in = (fy_ff == 32'sd0);
            div_neg_in  = fy_ff[31];
            div_den_in  = {1'b0, mass_ff};
            div_rem_in  = 33'd0;
            div_cnt_in  = 7'(rbvi_pkg::DIV_STEPS);
            state_in    = rbvi_pkg::ST_FY_DIV;
         end
         rbvi_pkg::ST_FY_ACC: begin
            ay_in    = rbvi_pkg::sat_add(ay_ff, div_q);
            state_in = rbvi_pkg::ST_DONE;
         end
         rbvi_pkg::ST_TQ_ACC: begin
            aw_in    = rbvi_pkg::sat_add(aw_ff, div_q);
            state_in = rbvi_pkg::ST_DONE;
         end
         rbvi_pkg::ST_VX_MUL: begin
            mul_a    = rbvi_pkg::mag32(ax_ff);
            mul_b    = 32'(dt_ff);
            state_in = rbvi_pkg::ST_VX_ADD;
         end
         rbvi_pkg::ST_VX_ADD: begin
            vx_in    = rbvi_pkg::add_mag(vx_ff, ax_ff[31],
                                         prod_ff[rbvi_pkg::DT_FRAC +: 33]);
            state_in = rbvi_pkg::ST_VY_MUL;
         end
         rbvi_pkg::ST_VY_MUL: begin
            mul_a    = rbvi_pkg::mag32(ay_ff);
            mul_b    = 32'(dt_ff);
            state_in = rbvi_pkg::ST_VY_ADD;
         end
         rbvi_pkg::ST_VY_ADD: begin
            vy_in    = rbvi_pkg::add_mag(vy_ff, ay_ff[31],
                                         prod_ff[rbvi_pkg::DT_FRAC +: 33]);
            ax_in    = 32'sd0;
            ay_in    = 32'sd0;
            state_in = (slim_ff != 31'd0) ? rbvi_pkg::ST_SQX_MUL : rbvi_pkg::ST_W_MUL;
         end
         rbvi_pkg::ST_SQX_MUL: begin
            mul_a    = rbvi_pkg::mag32(vx_ff);
            mul_b    = rbvi_pkg::mag32(vx_ff);
            state_in = rbvi_pkg::ST_SQY_MUL;
         end
         rbvi_pkg::ST_SQY_MUL: begin
            mul_a    = rbvi_pkg::mag32(vy_ff);
            mul_b    = rbvi_pkg::mag32(vy_ff);
            sum_in   = prod_ff;
            state_in = rbvi_pkg::ST_LIM_MUL;
         end
         rbvi_pkg::ST_LIM_MUL: begin
            mul_a    = {1'b0, slim_ff};
            mul_b    = {1'b0, slim_ff};
            sum_in   = sum_ff + prod_ff;
            state_in = rbvi_pkg::ST_CMP;
         end
         rbvi_pkg::ST_CMP: begin
            if (sum_ff > prod_ff) begin
               sq_x_in   = sum_ff;
               sq_res_in = 64'd0;
               sq_bit_in = 64'd1 << 62;
               sclamp_in = 1'b1;
               state_in  = rbvi_pkg::ST_SQRT;
            end else begin
               state_in  = rbvi_pkg::ST_W_MUL;
            end
         end
         rbvi_pkg::ST_SQRT: begin
            if (sq_bit_ff == 64'd0) begin
               state_in = rbvi_pkg::ST_RX_MUL;
            end else begin
               if (sq_x_ff >= sq_t) begin
                  sq_x_in   = sq_x_ff - sq_t;
                  sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_in = sq_res_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
            end
         end
         rbvi_pkg::ST_RX_MUL: begin
            mul_a    = rbvi_pkg::mag32(vx_ff);
            mul_b    = {1'b0, slim_ff};
            state_in = rbvi_pkg::ST_RX_LOAD;
         end
         rbvi_pkg::ST_RY_MUL: begin
            mul_a    = rbvi_pkg::mag32(vy_ff);
            mul_b    = {1'b0, slim_ff};
            state_in = rbvi_pkg::ST_RY_LOAD;
         end
         rbvi_pkg::ST_RX_LOAD, rbvi_pkg::ST_RY_LOAD: begin
            div_num_in  = prod_ff;
            div_zero_in = 1'b0;
            div_neg_in  = (state_ff == rbvi_pkg::ST_RX_LOAD) ? vx_ff[31] : vy_ff[31];
            div_den_in  = sq_res_ff[31:0];
            div_rem_in  = 33'd0;
            div_cnt_in  = 7'(rbvi_pkg::DIV_STEPS);
            state_in    = (state_ff == rbvi_pkg::ST_RX_LOAD) ? rbvi_pkg::ST_RX_DIV
                                                             : rbvi_pkg::ST_RY_DIV;
         end
         rbvi_pkg::ST_RX_SET: begin
            vx_in    = div_q;
            state_in = rbvi_pkg::ST_RY_MUL;
         end
         rbvi_pkg::ST_RY_SET: begin
            vy_in    = div_q;
            state_in = rbvi_pkg::ST_W_MUL;
         end
         rbvi_pkg::ST_W_MUL: begin
            mul_a    = rbvi_pkg::mag32(aw_ff);
            mul_b    = 32'(dt_ff);
            state_in = rbvi_pkg::ST_W_ADD;
         end
         rbvi_pkg::ST_W_ADD: begin
            vw_in    = rbvi_pkg::add_mag(vw_ff, aw_ff[31],
                                         prod_ff[rbvi_pkg::DT_FRAC +: 33]);
            aw_in    = 32'sd0;
            state_in = rbvi_pkg::ST_W_CLAMP;
         end
         rbvi_pkg::ST_W_CLAMP: begin
            if (wlim_ff != 31'd0) begin
               if (vw_ff > wlim_pos) begin
                  vw_in     = wlim_pos;
                  wclamp_in = 1'b1;
               end else if (vw_ff < wlim_neg) begin
                  vw_in     = wlim_neg;
                  wclamp_in = 1'b1;
               end
            end
            state_in = rbvi_pkg::ST_DONE;
         end
         rbvi_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.vel_x         = vx_ff;
               rsp_data_in.vel_y         = vy_ff;
               rsp_data_in.ang_vel       = vw_ff;
               rsp_data_in.speed_clamped = sclamp_ff;
               rsp_data_in.spin_clamped  = wclamp_ff;
               state_in                  = rbvi_pkg::ST_IDLE;
            end
         end
         default: state_in = rbvi_pkg::ST_IDLE;
      endcase

      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbvi_pkg::ST_IDLE;
         mass_ff      <= 31'd65536;
         slim_ff      <= 31'd0;
         wlim_ff      <= 31'd0;
         ax_ff        <= 32'sd0;
         ay_ff        <= 32'sd0;
         aw_ff        <= 32'sd0;
         vx_ff        <= 32'sd0;
         vy_ff        <= 32'sd0;
         vw_ff        <= 32'sd0;
         div_cnt_ff   <= 7'd0;
         sq_bit_ff    <= 64'd0;
         sclamp_ff    <= 1'b0;
         wclamp_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mass_ff      <= mass_in;
         slim_ff      <= slim_in;
         wlim_ff      <= wlim_in;
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         aw_ff        <= aw_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         vw_ff        <= vw_in;
         div_cnt_ff   <= div_cnt_in;
         sq_bit_ff    <= sq_bit_in;
         sclamp_ff    <= sclamp_in;
         wclamp_ff    <= wclamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fy_ff       <= fy_in;
      dt_ff       <= dt_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      sq_x_ff     <= sq_x_in;
      sq_res_ff   <= sq_res_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_neg_ff  <= div_neg_in;
      div_zero_ff <= div_zero_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rbvi_pkg::ST_DONE))
      else $error("result loaded outside the done step");

   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      (div_cnt_ff != 7'd0) |-> (state_ff == rbvi_pkg::ST_FX_DIV ||
         state_ff == rbvi_pkg::ST_FY_DIV || state_ff == rbvi_pkg::ST_TQ_DIV ||
         state_ff == rbvi_pkg::ST_RX_DIV || state_ff == rbvi_pkg::ST_RY_DIV))
      else $error("divider running outside a divide step");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbvi_pkg::ST_IDLE) |-> (div_cnt_ff == 7'd0))
      else $error("divider busy while idle");

   a_sclamp_needs_limit: assert property (@(posedge clock) disable iff (reset)
      (sclamp_ff && state_ff != rbvi_pkg::ST_IDLE) |-> (slim_ff != 31'd0))
      else $error("speed clamp without a speed limit");
`endif

endmodule
